@@ design/akl_pkg.sv @@
package akl_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned PROD_W   = 25;
  localparam int unsigned DEPTH    = 3;
  localparam int unsigned NUM_KEYS = 4;

  // floor(x / 10) == (x * 6554) >> 16 for every x below 2560
  localparam logic [12:0] DIV10_RECIP = 13'd6554;
  localparam int unsigned DIV10_SHIFT = 16;
  localparam logic [3:0]  ROUND_HALF  = 4'd5;

  localparam logic [CODE_W-1:0] KEY_NONE = 3'd0;
  localparam logic [CODE_W-1:0] KEY_1    = 3'd1;
  localparam logic [CODE_W-1:0] KEY_2    = 3'd2;
  localparam logic [CODE_W-1:0] KEY_3    = 3'd3;
  localparam logic [CODE_W-1:0] KEY_4    = 3'd4;

  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KEY1_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY1_HIGH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY2_LOW  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY2_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY3_LOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KEY3_HIGH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_KEY4_LOW  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_KEY4_HIGH = 3'd7;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
  } lvl_t;

endpackage

@@ design/akl_filter.sv @@
module akl_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [akl_pkg::SAMPLE_W-1:0]  in_sample,
  output akl_pkg::lvl_t                 lvl_out,
  input  logic                          lvl_ready
);

  logic                          smp_valid;
  logic [akl_pkg::SAMPLE_W-1:0]  smp;
  logic                          lvl_valid;
  logic [akl_pkg::LEVEL_W-1:0]   level;
  logic [akl_pkg::LEVEL_W-1:0]   level_next;
  logic [akl_pkg::LEVEL_W-1:0]   hist [akl_pkg::DEPTH];
  logic                          adv_lvl;
  logic                          adv_smp;
  logic [akl_pkg::SUM_W-1:0]     sum_r;
  logic [akl_pkg::PROD_W-1:0]    prod;

  assign adv_lvl  = !lvl_valid || lvl_ready;
  assign adv_smp  = smp_valid && adv_lvl;
  assign in_ready = !smp_valid || adv_lvl;

  // weighted sum plus half the divisor, so the truncating divide rounds half up
  always_comb begin
    sum_r = akl_pkg::SUM_W'(smp)
          + (akl_pkg::SUM_W'(hist[0]) << 2)
          + (akl_pkg::SUM_W'(hist[1]) << 1) + akl_pkg::SUM_W'(hist[1])
          + (akl_pkg::SUM_W'(hist[2]) << 1)
          + akl_pkg::SUM_W'(akl_pkg::ROUND_HALF);
    prod = akl_pkg::PROD_W'(sum_r) * akl_pkg::PROD_W'(akl_pkg::DIV10_RECIP);
    level_next = prod[akl_pkg::DIV10_SHIFT +: akl_pkg::LEVEL_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_ready) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid <= 1'b0;
    end else if (adv_lvl) begin
      lvl_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_smp) begin
      level <= level_next;
    end
  end

  // shift the newest level into the history as the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < akl_pkg::DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (adv_smp) begin
      hist[0] <= level_next;
      for (int i = 1; i < akl_pkg::DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  assign lvl_out.valid = lvl_valid;
  assign lvl_out.level = level;

`ifndef SYNTHESIS
  a_hist_tracks_level: assert property (@(posedge clk) disable iff (rst)
    adv_smp |=> lvl_valid && level == hist[0])
    else $error("history head differs from level register");
  a_level_holds: assert property (@(posedge clk) disable iff (rst)
    lvl_valid && !lvl_ready |=> lvl_valid && $stable(level))
    else $error("level changed while stalled");
  a_sample_holds: assert property (@(posedge clk) disable iff (rst)
    smp_valid && !adv_lvl |=> smp_valid && $stable(smp) && $stable(hist[0]))
    else $error("sample or history moved while stalled");
`endif

endmodule

@@ design/akl_keymatch.sv @@
module akl_keymatch (
  input  logic                           clk,
  input  logic                           rst,
  input  akl_pkg::lvl_t                  lvl_in,
  output logic                           lvl_ready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [akl_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [akl_pkg::CODE_W-1:0]     key_code,
  output logic [akl_pkg::LEVEL_W-1:0]    filtered_level
);

  logic [7:0]                    win_low  [akl_pkg::NUM_KEYS];
  logic [7:0]                    win_high [akl_pkg::NUM_KEYS];
  logic [akl_pkg::NUM_KEYS-1:0]  hit;
  logic [akl_pkg::CODE_W-1:0]    key_code_next;
  logic                          adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign lvl_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < akl_pkg::NUM_KEYS; k++) begin
        win_low[k]  <= '0;
        win_high[k] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        akl_pkg::REG_KEY1_LOW:  win_low[0]  <= cfg_data;
        akl_pkg::REG_KEY1_HIGH: win_high[0] <= cfg_data;
        akl_pkg::REG_KEY2_LOW:  win_low[1]  <= cfg_data;
        akl_pkg::REG_KEY2_HIGH: win_high[1] <= cfg_data;
        akl_pkg::REG_KEY3_LOW:  win_low[2]  <= cfg_data;
        akl_pkg::REG_KEY3_HIGH: win_high[2] <= cfg_data;
        akl_pkg::REG_KEY4_LOW:  win_low[3]  <= cfg_data;
        akl_pkg::REG_KEY4_HIGH: win_high[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < akl_pkg::NUM_KEYS; k++) begin
      hit[k] = (lvl_in.level > win_low[k]) && (lvl_in.level < win_high[k]);
    end
  end

  // a zero level never selects a key; lowest-numbered window wins
  always_comb begin
    if (lvl_in.level == '0) begin
      key_code_next = akl_pkg::KEY_NONE;
    end else if (hit[0]) begin
      key_code_next = akl_pkg::KEY_1;
    end else if (hit[1]) begin
      key_code_next = akl_pkg::KEY_2;
    end else if (hit[2]) begin
      key_code_next = akl_pkg::KEY_3;
    end else if (hit[3]) begin
      key_code_next = akl_pkg::KEY_4;
    end else begin
      key_code_next = akl_pkg::KEY_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= lvl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && lvl_in.valid) begin
      key_code       <= key_code_next;
      filtered_level <= lvl_in.level;
    end
  end

`ifndef SYNTHESIS
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_code <= akl_pkg::KEY_4)
    else $error("key code out of range");
  a_zero_no_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_code != akl_pkg::KEY_NONE |-> filtered_level != '0)
    else $error("key reported for zero level");
  a_key1_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_code == akl_pkg::KEY_1
      |-> filtered_level > win_low[0] && filtered_level < win_high[0])
    else $error("key 1 reported outside its window");
`endif

endmodule

@@ design/adc_key_ladder_decoder.sv @@
// Keypad decoder for a resistor-ladder keypad read through an 8-bit ADC.
// Input stream (s_axis_*): one raw ADC sample per item. Output stream
// (m_axis_*): one result per sample, the smoothed level and the key code
// (0 no key, 1 to 4 pressed key).
// The level is (sample + 4*h0 + 3*h1 + 2*h2) / 10 rounded half up, where
// h0..h2 are the last three levels, newest first. A nonzero level is tested
// against four windows low < level < high; the first key that matches wins.
// Window bounds are written over the cfg_* port, index 0..7 in the order
// key1_low, key1_high, ... key4_high; write them only while the block holds
// no item. cfg_ready is always high.
// A sample passes from the input register to the level register, where the
// divide-by-ten multiply forms the level, and then to the result register,
// which takes the window compares. Throughput: one item per cycle while
// m_axis_tready does not stall; the three-deep level history is updated in
// the same cycle the level is formed.
// A stall on m_axis_tready holds the result and backs up through the
// stages; s_axis_tready drops once all three registers are full.
// Reset clears the history, all window bounds and all valid flags.
module adc_key_ladder_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] key_code, [10:3] filtered_level, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  akl_pkg::lvl_t                  lvl;
  logic                           lvl_ready;
  logic [akl_pkg::CODE_W-1:0]     key_code;
  logic [akl_pkg::LEVEL_W-1:0]    filtered_level;

  akl_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata),
    .lvl_out   (lvl),
    .lvl_ready (lvl_ready)
  );

  akl_keymatch u_keymatch (
    .clk            (clk),
    .rst            (rst),
    .lvl_in         (lvl),
    .lvl_ready      (lvl_ready),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .key_code       (key_code),
    .filtered_level (filtered_level)
  );

  assign m_axis_tdata = {5'b0, filtered_level, key_code};

endmodule

@@ verif/adc_key_ladder_decoder_tb.sv @@
module adc_key_ladder_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  // register index of each key's window bounds, key 1 first
  localparam logic [akl_pkg::REG_IDX_W-1:0] LOW_REG[akl_pkg::NUM_KEYS] =
    '{akl_pkg::REG_KEY1_LOW, akl_pkg::REG_KEY2_LOW, akl_pkg::REG_KEY3_LOW,
      akl_pkg::REG_KEY4_LOW};
  localparam logic [akl_pkg::REG_IDX_W-1:0] HIGH_REG[akl_pkg::NUM_KEYS] =
    '{akl_pkg::REG_KEY1_HIGH, akl_pkg::REG_KEY2_HIGH, akl_pkg::REG_KEY3_HIGH,
      akl_pkg::REG_KEY4_HIGH};
  localparam logic [akl_pkg::CODE_W-1:0] KEY_CODE[akl_pkg::NUM_KEYS] =
    '{akl_pkg::KEY_1, akl_pkg::KEY_2, akl_pkg::KEY_3, akl_pkg::KEY_4};

  typedef struct packed {
    logic [akl_pkg::LEVEL_W-1:0] level;
    logic [akl_pkg::CODE_W-1:0]  code;
  } key_result_t;

  typedef enum int {WIN_LADDER, WIN_RANDOM, WIN_EXTREME, WIN_NESTED} window_style_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // predictor state
  logic [akl_pkg::LEVEL_W-1:0] level_history[akl_pkg::DEPTH];
  logic [7:0]                  window_reg[2*akl_pkg::NUM_KEYS];
  key_result_t                 pending_results[$];

  // window plan for the next register load
  logic [7:0] plan_lo[akl_pkg::NUM_KEYS];
  logic [7:0] plan_hi[akl_pkg::NUM_KEYS];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;
  int unsigned window_sets = 0;
  int unsigned key_hits = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  adc_key_ladder_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic key_result_t advance_filter(
      input logic [akl_pkg::SAMPLE_W-1:0] sample);
    int unsigned sum;
    int unsigned lvl;
    key_result_t r;
    sum = sample + 4 * level_history[0] + 3 * level_history[1] + 2 * level_history[2];
    lvl = sum / 10;
    if (sum % 10 >= 5) lvl++;
    if (lvl > 255) lvl = 255;
    level_history[2] = level_history[1];
    level_history[1] = level_history[0];
    level_history[0] = lvl[akl_pkg::LEVEL_W-1:0];
    r.level = lvl[akl_pkg::LEVEL_W-1:0];
    r.code  = akl_pkg::KEY_NONE;
    // scan from the top so the lowest matching key is left standing
    if (lvl != 0) begin
      for (int k = akl_pkg::NUM_KEYS - 1; k >= 0; k--) begin
        if (lvl > window_reg[LOW_REG[k]] && lvl < window_reg[HIGH_REG[k]])
          r.code = KEY_CODE[k];
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    key_result_t want;
    logic [akl_pkg::CODE_W-1:0]  got_code;
    logic [akl_pkg::LEVEL_W-1:0] got_level;
    if (rst) begin
      foreach (level_history[i]) level_history[i] = '0;
      foreach (window_reg[i]) window_reg[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) window_reg[cfg_index] = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(advance_filter(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got_code  = m_axis_tdata[akl_pkg::CODE_W-1:0];
        got_level = m_axis_tdata[akl_pkg::CODE_W +: akl_pkg::LEVEL_W];
        results_checked++;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected item code=%0d level=%0d", got_code, got_level));
        end else begin
          want = pending_results.pop_front();
          if (want.code != akl_pkg::KEY_NONE) key_hits++;
          if (got_code != want.code || got_level != want.level ||
              m_axis_tdata[15:akl_pkg::CODE_W+akl_pkg::LEVEL_W] != '0)
            note_mismatch($sformatf("code exp %0d got %0d, level exp %0d got %0d, pad %0h",
                                    want.code, got_code, want.level, got_level,
                                    m_axis_tdata[15:akl_pkg::CODE_W+akl_pkg::LEVEL_W]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 stall_cycles, pending_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [7:0] sample);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
  endtask

  // hold off the sender until every outstanding item is back
  task automatic wait_all_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [akl_pkg::REG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_windows();
    wait_all_results();
    for (int k = 0; k < akl_pkg::NUM_KEYS; k++) begin
      write_reg(LOW_REG[k], plan_lo[k]);
      write_reg(HIGH_REG[k], plan_hi[k]);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    window_sets++;
  endtask

  task automatic set_plan(input int k, input int lo, input int hi);
    plan_lo[k] = lo[7:0];
    plan_hi[k] = hi[7:0];
  endtask

  task automatic pick_windows(input window_style_e style);
    int centre;
    int half;
    int edge_val[4];
    edge_val = '{0, 1, 254, 255};
    for (int k = 0; k < akl_pkg::NUM_KEYS; k++) begin
      case (style)
        WIN_LADDER: begin
          centre = 30 + 55 * k + $urandom_range(20) - 10;
          half   = $urandom_range(25, 1);
          set_plan(k, centre - half, centre + half);
        end
        WIN_RANDOM: set_plan(k, $urandom_range(255), $urandom_range(255));
        WIN_EXTREME: set_plan(k, edge_val[$urandom_range(3)], edge_val[$urandom_range(3)]);
        default: set_plan(k, $urandom_range(100), $urandom_range(255, 150));
      endcase
    end
  endtask

  // a steady sample near the middle of a key's window, or anywhere if it is empty
  function automatic int press_target(input int k);
    if (plan_hi[k] > plan_lo[k] + 1) return (plan_lo[k] + plan_hi[k]) / 2;
    return $urandom_range(255);
  endfunction

  task automatic test_default_windows();
    // all bounds zero after reset: nothing can match
    send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd128);
  endtask

  task automatic test_window_edges();
    // full-range windows: every nonzero level below 255 hits key 1
    for (int k = 0; k < akl_pkg::NUM_KEYS; k++) set_plan(k, 0, 255);
    program_windows();
    repeat (4) send_sample(8'd255);
    // let the level decay on zero samples, then feed samples of one
    repeat (4) send_sample(8'd0);
    repeat (2) send_sample(8'd1);
    // inverted, empty and overlapping windows
    set_plan(0, 255, 0);
    set_plan(1, 100, 101);
    set_plan(2, 20, 200);
    set_plan(3, 0, 255);
    program_windows();
    repeat (6) send_sample(8'd200);
    repeat (4) send_sample(8'd0);
  endtask

  task automatic test_random_presses(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned num_samples);
    int unsigned sent;
    int unsigned run_len;
    int target;
    int value;
    int unsigned pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < num_samples) begin
      if (sent % 100 == 0) begin
        pick_windows(window_style_e'($urandom_range(3)));
        program_windows();
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        // key held: a run of noisy samples around one window
        target  = press_target($urandom_range(akl_pkg::NUM_KEYS - 1));
        run_len = $urandom_range(12, 3);
        repeat (run_len) begin
          value = target + $urandom_range(6) - 3;
          if (value < 0) value = 0;
          if (value > 255) value = 255;
          send_sample(value[7:0]);
        end
        sent += run_len;
      end else if (pick < 85) begin
        run_len = $urandom_range(8, 3);
        repeat (run_len) send_sample(8'd0);
        sent += run_len;
      end else begin
        send_sample(8'($urandom_range(255)));
        sent++;
      end
      if ($urandom_range(59) == 0) wait_all_results();
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_default_windows();
    test_window_edges();
    test_random_presses(17, 87, 500);
    test_random_presses(87, 17, 500);
    test_random_presses(0, 0, 500);
    wait_all_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d samples, checked %0d results (%0d with a key pressed)",
             samples_sent, results_checked, key_hits);
    $display("Used %0d window settings, %0d mismatches", window_sets, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
